/* src/fln_pkg.sv */
// fln_pkg: shared types, float constants and helper functions for the natural log block
// used by fln_fadd, fln_fmul, fln_fdiv and float32_natural_log; no dependencies
`timescale 1ns / 1ps

package fln_pkg;

  // pipeline depth of each float unit, input register to output register
  localparam int MUL_LAT = 2;
  localparam int ADD_LAT = 4;
  localparam int QUO_BITS = 26;
  localparam int DIV_LAT = QUO_BITS + 2;

  localparam int EXP_BIAS = 127;

  localparam logic [31:0] F32_ONE = 32'h3F80_0000;
  localparam logic [31:0] F32_HALF = 32'h3F00_0000;
  localparam logic [31:0] F32_THIRD = 32'h3EAA_AAAB;
  localparam logic [31:0] F32_LN2 = 32'h3F31_7218;
  localparam logic [31:0] F32_NEAR_LO = 32'h3F7D_70A4;
  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] F32_NEG_INF = 32'hFF80_0000;

  typedef logic signed [9:0] exp_t;

  // round to nearest even and pack; mant carries the hidden bit
  function automatic logic [31:0] round_pack(logic sign, exp_t exp, logic [23:0] mant,
                                             logic g, logic st);
    logic inc;
    logic [30:0] mag;
    inc = g & (st | mant[0]);
    mag = {exp[7:0], mant[22:0]} + {30'd0, inc};
    return {sign, mag};
  endfunction

  // leading zero count of a 27 bit word, 27 when the word is zero
  function automatic logic [4:0] lzc27(logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  // nearest single to a positive normal real, evaluated at elaboration
  function automatic logic [31:0] real_to_f32(real v);
    logic [63:0] b;
    exp_t e;
    b = $realtobits(v);
    e = exp_t'(int'(b[62:52]) - 1023 + EXP_BIAS);
    return round_pack(1'b0, e, {1'b1, b[51:29]}, b[28], |b[27:0]);
  endfunction

  // table entry 1/(1 + k/2^ib)
  function automatic logic [31:0] recip_entry(int k, int ib);
    real t;
    real y;
    t = 1.0 + real'(k) * $pow(2.0, -real'(ib));
    // newton steps from a linear guess, the error squares on each step
    y = 1.5 - 0.5 * t;
    for (int i = 0; i < 6; i++) begin
      y = y * (2.0 - t * y);
    end
    return real_to_f32(y);
  endfunction

  // table entry ln(1 + k/2^ib)
  function automatic logic [31:0] ln_entry(int k, int ib);
    real t;
    t = 1.0 + real'(k) * $pow(2.0, -real'(ib));
    if (k == 0) return 32'd0;
    return real_to_f32($ln(t));
  endfunction

endpackage

/* src/fln_fmul.sv */
// fln_fmul: two stage single precision multiplier, round to nearest even
// operands are zero or normal, product assumed normal or zero; uses fln_pkg
`timescale 1ns / 1ps

module fln_fmul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import fln_pkg::*;

  logic        p_sign;
  logic        p_zero;
  exp_t        p_exp;
  logic [47:0] p_prod;
  logic [23:0] ma;
  logic [23:0] mb;
  logic [23:0] n_mant;
  logic        n_g;
  logic        n_st;
  exp_t        n_exp;
  logic [31:0] y_next;

  assign ma = {1'b1, a[22:0]};
  assign mb = {1'b1, b[22:0]};

  // stage 1: mantissa product and exponent sum
  always_ff @(posedge clk) begin
    p_sign <= a[31] ^ b[31];
    p_zero <= (a[30:23] == 8'd0) || (b[30:23] == 8'd0);
    p_exp  <= exp_t'({2'b00, a[30:23]}) + exp_t'({2'b00, b[30:23]}) - exp_t'(EXP_BIAS);
    p_prod <= 48'(ma) * 48'(mb);
  end

  // stage 2: one bit normalize and round
  always_comb begin
    if (p_prod[47]) begin
      n_mant = p_prod[47:24];
      n_g    = p_prod[23];
      n_st   = |p_prod[22:0];
      n_exp  = p_exp + exp_t'(1);
    end else begin
      n_mant = p_prod[46:23];
      n_g    = p_prod[22];
      n_st   = |p_prod[21:0];
      n_exp  = p_exp;
    end
    y_next = p_zero ? {p_sign, 31'd0} : round_pack(p_sign, n_exp, n_mant, n_g, n_st);
  end

  always_ff @(posedge clk) begin
    y <= y_next;
  end

endmodule

/* src/fln_fadd.sv */
// fln_fadd: four stage single precision adder, round to nearest even
// operands are zero or normal, sum assumed normal or zero; uses fln_pkg
`timescale 1ns / 1ps

module fln_fadd (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import fln_pkg::*;

  logic        swap;
  logic [31:0] big;
  logic [31:0] small_op;

  logic        s1_sign;
  logic        s1_sub;
  logic [7:0]  s1_exp;
  logic [7:0]  s1_diff;
  logic [23:0] s1_mbig;
  logic [23:0] s1_msmall;

  logic [26:0] small_ext;
  logic [26:0] shifted;
  logic        lost;
  logic [26:0] aligned;
  logic [27:0] big_ext;
  logic [27:0] sum_next;

  logic        s2_sign;
  logic        s2_sub;
  exp_t        s2_exp;
  logic [27:0] s2_sum;

  logic [4:0]  lz;
  logic [26:0] norm_next;
  exp_t        nexp;

  logic        s3_sign;
  logic        s3_sub;
  logic        s3_zero;
  exp_t        s3_exp;
  logic [26:0] s3_norm;

  logic [31:0] y_next;

  // stage 1: order by magnitude
  always_comb begin
    swap     = b[30:0] > a[30:0];
    big      = swap ? b : a;
    small_op = swap ? a : b;
  end

  always_ff @(posedge clk) begin
    s1_sign   <= big[31];
    s1_sub    <= a[31] ^ b[31];
    s1_exp    <= big[30:23];
    s1_diff   <= big[30:23] - small_op[30:23];
    s1_mbig   <= {big[30:23] != 8'd0, big[22:0]};
    s1_msmall <= {small_op[30:23] != 8'd0, small_op[22:0]};
  end

  // stage 2: align with guard, round and sticky, then add or subtract
  always_comb begin
    small_ext = {s1_msmall, 3'b000};
    shifted   = small_ext >> s1_diff;
    lost      = |(small_ext & ~(27'h7FF_FFFF << s1_diff));
    if (s1_diff >= 8'd27) begin
      aligned = {26'd0, |s1_msmall};
    end else begin
      aligned = {shifted[26:1], shifted[0] | lost};
    end
    big_ext  = {1'b0, s1_mbig, 3'b000};
    sum_next = s1_sub ? big_ext - {1'b0, aligned} : big_ext + {1'b0, aligned};
  end

  always_ff @(posedge clk) begin
    s2_sign <= s1_sign;
    s2_sub  <= s1_sub;
    s2_exp  <= exp_t'({2'b00, s1_exp});
    s2_sum  <= sum_next;
  end

  // stage 3: normalize
  always_comb begin
    lz = lzc27(s2_sum[26:0]);
    if (s2_sum[27]) begin
      norm_next = {s2_sum[27:2], s2_sum[1] | s2_sum[0]};
      nexp      = s2_exp + exp_t'(1);
    end else begin
      norm_next = s2_sum[26:0] << lz;
      nexp      = s2_exp - exp_t'({5'd0, lz});
    end
  end

  always_ff @(posedge clk) begin
    s3_sign <= s2_sign;
    s3_sub  <= s2_sub;
    s3_zero <= s2_sum == 28'd0;
    s3_exp  <= nexp;
    s3_norm <= norm_next;
  end

  // stage 4: round; exact cancellation gives +0
  always_comb begin
    if (s3_zero) begin
      y_next = {s3_sign & ~s3_sub, 31'd0};
    end else begin
      y_next = round_pack(s3_sign, s3_exp, s3_norm[26:3], s3_norm[2], |s3_norm[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    y <= y_next;
  end

endmodule

/* src/fln_fdiv.sv */
// fln_fdiv: pipelined radix-2 restoring single precision divider, one quotient bit a stage
// numerator zero or normal, divisor normal, quotient assumed normal or zero; uses fln_pkg
`timescale 1ns / 1ps

module fln_fdiv (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import fln_pkg::*;

  logic [QUO_BITS-1:0] q_st    [QUO_BITS+1];
  logic [25:0]         rem_st  [QUO_BITS+1];
  logic [23:0]         dv_st   [QUO_BITS+1];
  exp_t                exp_st  [QUO_BITS+1];
  logic                sign_st [QUO_BITS+1];
  logic                zero_st [QUO_BITS+1];

  logic [QUO_BITS-1:0] qf;
  logic [23:0]         f_mant;
  logic                f_g;
  logic                f_st;
  exp_t                f_exp;
  logic [31:0]         y_next;

  // setup stage
  always_ff @(posedge clk) begin
    q_st[0]    <= '0;
    rem_st[0]  <= {2'b00, 1'b1, a[22:0]};
    dv_st[0]   <= {1'b1, b[22:0]};
    exp_st[0]  <= exp_t'({2'b00, a[30:23]}) - exp_t'({2'b00, b[30:23]}) + exp_t'(EXP_BIAS);
    sign_st[0] <= a[31] ^ b[31];
    zero_st[0] <= a[30:23] == 8'd0;
  end

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_iter
    logic        take;
    logic [25:0] trial;
    assign take  = rem_st[i] >= {2'b00, dv_st[i]};
    assign trial = rem_st[i] - {2'b00, dv_st[i]};
    always_ff @(posedge clk) begin
      rem_st[i+1]  <= take ? {trial[24:0], 1'b0} : {rem_st[i][24:0], 1'b0};
      q_st[i+1]    <= {q_st[i][QUO_BITS-2:0], take};
      dv_st[i+1]   <= dv_st[i];
      exp_st[i+1]  <= exp_st[i];
      sign_st[i+1] <= sign_st[i];
      zero_st[i+1] <= zero_st[i];
    end
  end

  // final stage: normalize by at most one bit and round
  always_comb begin
    qf = q_st[QUO_BITS];
    if (qf[QUO_BITS-1]) begin
      f_mant = qf[QUO_BITS-1:QUO_BITS-24];
      f_g    = qf[1];
      f_st   = qf[0] | (rem_st[QUO_BITS] != 26'd0);
      f_exp  = exp_st[QUO_BITS];
    end else begin
      f_mant = qf[QUO_BITS-2:QUO_BITS-25];
      f_g    = qf[0];
      f_st   = rem_st[QUO_BITS] != 26'd0;
      f_exp  = exp_st[QUO_BITS] - exp_t'(1);
    end
    if (zero_st[QUO_BITS]) begin
      y_next = {sign_st[QUO_BITS], 31'd0};
    end else begin
      y_next = round_pack(sign_st[QUO_BITS], f_exp, f_mant, f_g, f_st);
    end
  end

  always_ff @(posedge clk) begin
    y <= y_next;
  end

endmodule

/* src/float32_natural_log.sv */
// float32_natural_log: fully pipelined natural log of an IEEE single bit pattern
// depends on fln_pkg, fln_fadd, fln_fmul and fln_fdiv
`timescale 1ns / 1ps

// channel    direction  signals                 transfer
// operand    in         start, busy, x_bits     start high and busy low at a clock edge
// result     out        done, log_bits          done high for one cycle, always taken
//
// one operand a cycle; each operand passes through these stages in order to its result
// (three front-end stages, 43 stages of table reads and float units, one output stage)
// the divider's one-quotient-bit-per-stage pipeline sets most of the depth
// busy is always low: the receiver cannot stall, so nothing ever backs up
// rst clears only the valid chain; data registers are left alone

module float32_natural_log #(
  parameter int TABLE_INDEX_BITS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] x_bits,
  output logic        done,
  output logic [31:0] log_bits
);
  import fln_pkg::*;

  localparam int ROM_SIZE = 1 << TABLE_INDEX_BITS;

  // arrival times counted from the decode register
  localparam int T_S    = 1 + MUL_LAT;          // s = u * recip
  localparam int T_DD   = T_S + ADD_LAT;        // s - 1 and s + 1
  localparam int T_A    = T_DD + DIV_LAT;       // quotient
  localparam int T_R1   = T_A + ADD_LAT;        // e*ln2 + quotient
  localparam int T_TAB  = T_R1 + ADD_LAT;       // plus table log
  localparam int T_LE   = 1 + MUL_LAT;          // e*ln2
  localparam int NS     = ADD_LAT;              // near path s = 1 - x
  localparam int N1     = NS + ADD_LAT;
  localparam int N2     = N1 + MUL_LAT;
  localparam int N3     = N2 + ADD_LAT;
  localparam int N4     = N3 + MUL_LAT;
  localparam int N5     = N4 + ADD_LAT;
  localparam int T_NEAR = N5 + MUL_LAT;
  localparam int TOTAL_LAT = T_TAB + 4;         // accept edge to done

  // constant tables
  logic [31:0] recip_rom [ROM_SIZE];
  logic [31:0] ln_rom    [ROM_SIZE];

  for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
    localparam logic [31:0] RECIP_V = recip_entry(g, TABLE_INDEX_BITS);
    localparam logic [31:0] LN_V    = ln_entry(g, TABLE_INDEX_BITS);
    assign recip_rom[g] = RECIP_V;
    assign ln_rom[g]    = LN_V;
  end

  assign busy = 1'b0;

  // stage a: capture the operand
  logic        a_vld;
  logic [31:0] a_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start;
    end
    a_x <= x_bits;
  end

  // stage b: leading zero count of the mantissa for subnormals
  logic        b_vld;
  logic [31:0] b_x;
  logic [4:0]  b_lz;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_x  <= a_x;
    b_lz <= lzc27({a_x[22:0], 4'd0});
  end

  // stage c: classify, normalize subnormals, split into exponent and 1.m
  logic [7:0]                  b_ef;
  logic [22:0]                 b_mant;
  logic [22:0]                 mant_n;
  logic signed [8:0]           e_next;
  logic                        special_next;
  logic [31:0]                 special_bits_next;
  logic                        near_next;

  assign b_ef   = b_x[30:23];
  assign b_mant = b_x[22:0];

  always_comb begin
    if (b_ef == 8'd0) begin
      // subnormal: shift the leading one out into the hidden position
      mant_n = b_mant << (b_lz + 5'd1);
      e_next = -9'sd127 - $signed({4'd0, b_lz});
    end else begin
      mant_n = b_mant;
      e_next = $signed({1'b0, b_ef}) - 9'sd127;
    end
    special_next      = 1'b1;
    special_bits_next = b_x;
    if (b_x[31]) begin
      special_bits_next = F32_QNAN;
    end else if (b_ef == 8'hFF) begin
      special_bits_next = b_x;
    end else if (b_x[30:0] == 31'd0) begin
      special_bits_next = F32_NEG_INF;
    end else begin
      special_next = 1'b0;
    end
    // only positive normals reach this window
    near_next = (b_x > F32_NEAR_LO) && (b_x < F32_ONE);
  end

  logic                        c_vld;
  logic [31:0]                 c_x;
  logic [31:0]                 c_u;
  logic [TABLE_INDEX_BITS-1:0] c_k;
  logic signed [8:0]           c_e;
  logic                        c_special;
  logic [31:0]                 c_special_bits;
  logic                        c_near;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_x            <= b_x;
    c_u            <= {1'b0, 8'(EXP_BIAS), mant_n};
    c_k            <= mant_n[22 -: TABLE_INDEX_BITS];
    c_e            <= e_next;
    c_special      <= special_next;
    c_special_bits <= special_bits_next;
    c_near         <= near_next;
  end

  // table path, first stage: table reads and exponent to float (exact)
  logic [7:0]  e_mag;
  logic [4:0]  e_lz;
  logic [7:0]  e_sh;
  logic [31:0] ef_next;

  always_comb begin
    e_mag = c_e[8] ? 8'(-c_e) : 8'(c_e);
    e_lz  = lzc27({e_mag, 19'd0});
    e_sh  = e_mag << e_lz[2:0];
    if (c_e == 9'sd0) begin
      ef_next = 32'd0;
    end else begin
      ef_next = {c_e[8], 8'(EXP_BIAS + 7) - {5'd0, e_lz[2:0]}, e_sh[6:0], 16'd0};
    end
  end

  logic [31:0] t1_recip;
  logic [31:0] t1_lnrom;
  logic [31:0] t1_u;
  logic [31:0] t1_ef;

  always_ff @(posedge clk) begin
    t1_recip <= recip_rom[c_k];
    t1_lnrom <= ln_rom[c_k];
    t1_u     <= c_u;
    t1_ef    <= ef_next;
  end

  // s = u * (1/t), then 2(s-1) / (s+1)
  logic [31:0] ts;
  logic [31:0] td;
  logic [31:0] tden;
  logic [31:0] td2;
  logic [31:0] ta;

  fln_fmul u_mul_s (.clk(clk), .a(t1_u), .b(t1_recip), .y(ts));
  fln_fadd u_add_d (.clk(clk), .a(ts), .b({1'b1, F32_ONE[30:0]}), .y(td));
  fln_fadd u_add_den (.clk(clk), .a(ts), .b(F32_ONE), .y(tden));

  // doubling is an exponent bump unless s - 1 is zero
  assign td2 = (td[30:23] == 8'd0) ? td : {td[31], td[30:23] + 8'd1, td[22:0]};

  fln_fdiv u_div (.clk(clk), .a(td2), .b(tden), .y(ta));

  // e * ln2, held until the quotient arrives
  logic [31:0] tle;
  logic [31:0] le_line [T_A - T_LE];

  fln_fmul u_mul_ln2 (.clk(clk), .a(F32_LN2), .b(t1_ef), .y(tle));

  always_ff @(posedge clk) begin
    le_line[0] <= tle;
    for (int i = 1; i < T_A - T_LE; i++) begin
      le_line[i] <= le_line[i-1];
    end
  end

  // table log held until the second sum
  logic [31:0] ln_line [T_R1 - 1];

  always_ff @(posedge clk) begin
    ln_line[0] <= t1_lnrom;
    for (int i = 1; i < T_R1 - 1; i++) begin
      ln_line[i] <= ln_line[i-1];
    end
  end

  logic [31:0] tr1;
  logic [31:0] tr2;

  fln_fadd u_add_r1 (.clk(clk), .a(le_line[T_A-T_LE-1]), .b(ta), .y(tr1));
  fln_fadd u_add_r2 (.clk(clk), .a(tr1), .b(ln_line[T_R1-2]), .y(tr2));

  // near one path: horner series in s = 1 - x
  logic [31:0] ns;
  logic [31:0] nq;
  logic [31:0] n1;
  logic [31:0] n2;
  logic [31:0] n3;
  logic [31:0] n4;
  logic [31:0] n5;
  logic [31:0] n6;
  logic [31:0] s_line [N5 - NS];
  logic [31:0] s_tap5;

  fln_fadd u_add_ns (.clk(clk), .a(F32_ONE), .b({~c_x[31], c_x[30:0]}), .y(ns));

  always_ff @(posedge clk) begin
    s_line[0] <= ns;
    for (int i = 1; i < N5 - NS; i++) begin
      s_line[i] <= s_line[i-1];
    end
  end

  // s * 0.25 is exact: s is at least 2^-24
  assign nq     = {ns[31], ns[30:23] - 8'd2, ns[22:0]};
  assign s_tap5 = s_line[N5-NS-1];

  fln_fadd u_add_n1 (.clk(clk), .a(F32_THIRD), .b(nq), .y(n1));
  fln_fmul u_mul_n2 (.clk(clk), .a(s_line[N1-NS-1]), .b(n1), .y(n2));
  fln_fadd u_add_n3 (.clk(clk), .a(F32_HALF), .b(n2), .y(n3));
  fln_fmul u_mul_n4 (.clk(clk), .a(s_line[N3-NS-1]), .b(n3), .y(n4));
  fln_fadd u_add_n5 (.clk(clk), .a(F32_ONE), .b(n4), .y(n5));
  fln_fmul u_mul_n6 (.clk(clk), .a({~s_tap5[31], s_tap5[30:0]}), .b(n5), .y(n6));

  logic [31:0] near_line [T_TAB - T_NEAR];

  always_ff @(posedge clk) begin
    near_line[0] <= n6;
    for (int i = 1; i < T_TAB - T_NEAR; i++) begin
      near_line[i] <= near_line[i-1];
    end
  end

  // valid and path selection travel beside the float units
  logic        vld_line     [T_TAB];
  logic        spec_line    [T_TAB];
  logic [31:0] spec_bits_ln [T_TAB];
  logic        near_line_f  [T_TAB];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < T_TAB; i++) begin
        vld_line[i] <= 1'b0;
      end
    end else begin
      vld_line[0] <= c_vld;
      for (int i = 1; i < T_TAB; i++) begin
        vld_line[i] <= vld_line[i-1];
      end
    end
    spec_line[0]    <= c_special;
    spec_bits_ln[0] <= c_special_bits;
    near_line_f[0]  <= c_near;
    for (int i = 1; i < T_TAB; i++) begin
      spec_line[i]    <= spec_line[i-1];
      spec_bits_ln[i] <= spec_bits_ln[i-1];
      near_line_f[i]  <= near_line_f[i-1];
    end
  end

  // output register
  logic [31:0] log_next;

  always_comb begin
    if (spec_line[T_TAB-1]) begin
      log_next = spec_bits_ln[T_TAB-1];
    end else if (near_line_f[T_TAB-1]) begin
      log_next = near_line[T_TAB-T_NEAR-1];
    end else begin
      log_next = tr2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_line[T_TAB-1];
    end
    log_bits <= log_next;
  end

  // a result only follows an operand transfer a fixed latency earlier
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, TOTAL_LAT))
    else $error("result without matching operand");

  // negative operands give the quiet nan
  assert property (@(posedge clk) disable iff (rst)
    done && $past(x_bits[31], TOTAL_LAT) |-> log_bits == F32_QNAN)
    else $error("negative operand did not give nan");

  // positive zero gives minus infinity
  assert property (@(posedge clk) disable iff (rst)
    done && $past(x_bits == 32'd0, TOTAL_LAT) |-> log_bits == F32_NEG_INF)
    else $error("zero operand did not give minus infinity");

  // positive finite nonzero operands never give inf or nan
  assert property (@(posedge clk) disable iff (rst)
    done && $past(!x_bits[31] && x_bits[30:23] != 8'hFF && x_bits[30:0] != 31'd0,
                  TOTAL_LAT)
    |-> log_bits[30:23] != 8'hFF)
    else $error("finite operand gave inf or nan");

endmodule

/* bench/testbench.sv */
// testbench: self-checking regression for float32_natural_log
// depends on fln_pkg and the float32_natural_log rtl; carries its own bit-exact log predictor
`timescale 1ns / 1ps

module testbench;

  localparam int IDX_BITS = 7;
  localparam int ROM_N = 1 << IDX_BITS;
  localparam int PIPE_DEPTH = 47;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1430;
  localparam logic [31:0] F_QUARTER = 32'h3E80_0000;
  localparam logic [31:0] F_TWO = 32'h4000_0000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [31:0] x_bits;
  logic done;
  logic [31:0] log_bits;

  int errors;
  int cycles;
  logic [31:0] recip_rom [ROM_N];
  logic [31:0] ln_rom [ROM_N];

  float32_natural_log #(.TABLE_INDEX_BITS(IDX_BITS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_bits(x_bits), .done(done), .log_bits(log_bits)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // single precision arithmetic, exact intermediate then one round to nearest even
  // ---------------------------------------------------------------------------

  // value = m * 2^e, normal results only
  function automatic logic [31:0] round_even(bit sgn, logic [127:0] m, int e);
    int p;
    int sh;
    int be;
    logic [127:0] keep;
    bit g;
    bit st;
    if (m == 0) return {sgn, 31'd0};
    p = 0;
    for (int i = 0; i < 128; i++) if (m[i]) p = i;
    if (p > 23) begin
      sh = p - 23;
      keep = m >> sh;
      g = m[sh-1];
      st = (sh > 1) ? |(m & ((128'd1 << (sh - 1)) - 128'd1)) : 1'b0;
      e += sh;
      if (g && (st || keep[0])) keep++;
      if (keep[24]) begin
        keep >>= 1;
        e++;
      end
    end else begin
      keep = m << (23 - p);
      e -= 23 - p;
    end
    be = e + 23 + 127;
    return {sgn, be[7:0], keep[22:0]};
  endfunction

  // split a normal or zero operand into mantissa and exponent
  function automatic void split(input logic [31:0] f, output bit sgn,
                                output logic [127:0] m, output int e);
    sgn = f[31];
    if (f[30:23] == 8'd0) begin
      m = '0;
      e = 0;
    end else begin
      m = {104'd0, 1'b1, f[22:0]};
      e = int'(f[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    bit sa, sb, sr;
    logic [127:0] ma, mb, mr, tm;
    int ea, eb, d, te;
    bit ts;
    split(a, sa, ma, ea);
    split(b, sb, mb, eb);
    if (ma == 0 && mb == 0) return {sa & sb, 31'd0};
    if (ma == 0) return b;
    if (mb == 0) return a;
    if (eb > ea) begin
      tm = ma; ma = mb; mb = tm;
      te = ea; ea = eb; eb = te;
      ts = sa; sa = sb; sb = ts;
    end
    d = ea - eb;
    // far-away addend only matters as a sticky bit
    if (d > 60) begin
      mb = 128'd1;
      eb = ea - 60;
      d = 60;
    end
    ma = ma << d;
    if (sa == sb) begin
      mr = ma + mb;
      sr = sa;
    end else if (ma >= mb) begin
      mr = ma - mb;
      sr = sa;
    end else begin
      mr = mb - ma;
      sr = sb;
    end
    if (mr == 0) return 32'd0;
    return round_even(sr, mr, eb);
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    bit sa, sb;
    logic [127:0] ma, mb;
    int ea, eb;
    split(a, sa, ma, ea);
    split(b, sb, mb, eb);
    if (ma == 0 || mb == 0) return {sa ^ sb, 31'd0};
    return round_even(sa ^ sb, ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
    bit sa, sb;
    logic [127:0] ma, mb, q;
    int ea, eb;
    split(a, sa, ma, ea);
    split(b, sb, mb, eb);
    if (ma == 0) return {sa ^ sb, 31'd0};
    q = (ma << 60) / mb;
    if ((ma << 60) % mb != 0) q[0] = 1'b1;
    return round_even(sa ^ sb, q, ea - eb - 60);
  endfunction

  function automatic logic [31:0] f_from_int(int v);
    return round_even(v < 0, 128'(v < 0 ? -v : v), 0);
  endfunction

  function automatic logic [31:0] f_from_real(real v);
    logic [63:0] b;
    b = $realtobits(v);
    if (b[62:0] == 0) return 32'd0;
    return round_even(b[63], {75'd0, 1'b1, b[51:0]}, int'(b[62:52]) - 1075);
  endfunction

  // ln(x) as the block computes it
  function automatic logic [31:0] ln_of(logic [31:0] xb);
    logic [7:0] ef;
    logic [22:0] mant;
    int e;
    int p;
    int k;
    logic [31:0] s, r, u, d, den, a;
    ef = xb[30:23];
    mant = xb[22:0];
    if (xb[31]) return fln_pkg::F32_QNAN;
    if (ef == 8'hFF) return xb;
    if (ef == 8'd0 && mant == 0) return fln_pkg::F32_NEG_INF;
    if (ef == 8'd0) begin
      // subnormal: normalize, skip the near-one test
      p = 22;
      while (p > 0 && !mant[p]) p--;
      e = p - 149;
      mant = mant << (23 - p);
    end else if (xb > fln_pkg::F32_NEAR_LO && xb < fln_pkg::F32_ONE) begin
      // horner series in s = 1 - x
      s = f_add(fln_pkg::F32_ONE, {1'b1, xb[30:0]});
      r = f_mul(s, F_QUARTER);
      r = f_add(fln_pkg::F32_THIRD, r);
      r = f_mul(s, r);
      r = f_add(fln_pkg::F32_HALF, r);
      r = f_mul(s, r);
      r = f_add(fln_pkg::F32_ONE, r);
      return f_mul({~s[31], s[30:0]}, r);
    end else begin
      e = int'(ef) - 127;
    end
    k = int'(mant >> (23 - IDX_BITS));
    u = {1'b0, 8'd127, mant};
    s = f_mul(u, recip_rom[k]);
    d = f_add(s, {1'b1, fln_pkg::F32_ONE[30:0]});
    d = f_mul(F_TWO, d);
    den = f_add(s, fln_pkg::F32_ONE);
    a = f_div(d, den);
    r = f_mul(fln_pkg::F32_LN2, f_from_int(e));
    r = f_add(r, a);
    return f_add(r, ln_rom[k]);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got %08h want %08h", cycles, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // scoreboard: expected log results in transfer order
  // ---------------------------------------------------------------------------
  class log_scoreboard;
    logic [31:0] pending_logs[$];
    logic [31:0] pending_args[$];
    int taken;
    int checked;

    function void note_operand(logic [31:0] xb);
      pending_args.push_back(xb);
      pending_logs.push_back(ln_of(xb));
      taken++;
    endfunction

    task check_result(logic [31:0] got);
      logic [31:0] want;
      logic [31:0] arg;
      if (pending_logs.size() == 0) begin
        report_mismatch("unexpected result", got, 32'd0);
        return;
      end
      want = pending_logs.pop_front();
      arg = pending_args.pop_front();
      checked++;
      if (got !== want) report_mismatch($sformatf("log_bits for x %08h", arg), got, want);
    endtask
  endclass

  log_scoreboard board = new();

  // monitor: operand transfer and result strobe, both sampled at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_operand(x_bits);
      if (done) board.check_result(log_bits);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("float32_natural_log regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // operand driver
  // ---------------------------------------------------------------------------
  bit quiet_run;

  // one operand transfer, at times with a random gap in front of it
  task automatic send_operand(logic [31:0] xb);
    if (!quiet_run && $urandom_range(99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start <= 1'b1;
    x_bits <= xb;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic go_idle();
    start <= 1'b0;
    x_bits <= $urandom;
    @(posedge clk);
  endtask

  // random operand weighted toward the interesting regions
  function automatic logic [31:0] pick_operand();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return $urandom;
    if (sel < 45) return $urandom_range(32'h3F7F_FFFF, 32'h3F7D_70A5);
    if (sel < 55) return $urandom_range(32'h3F83_0000, 32'h3F70_0000);
    if (sel < 65) return {9'd0, 23'($urandom)};
    if (sel < 90) return {1'b0, 8'($urandom_range(254, 1)), 23'($urandom)};
    if (sel < 95) return {1'b0, 8'hFF, 23'($urandom_range(1) ? $urandom : 0)};
    return {1'b1, 31'($urandom)};
  endfunction

  logic [31:0] corner_operands[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
    32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001, 32'h007F_FFFF,
    32'h0040_0000, 32'h0080_0000, 32'h3F80_0000, 32'h3F7F_FFFF, 32'h3F7D_70A4,
    32'h3F7D_70A5, 32'h3F7E_0000, 32'h7F7F_FFFF, 32'h3F00_0000, 32'h4000_0000,
    32'h3FFF_FFFF, 32'h3FC0_0000, 32'h3F81_0000, 32'hBF80_0000, 32'h5555_5555
  };

  initial begin
    real t;
    int waited;
    rst = 1'b1;
    start = 1'b0;
    x_bits = 32'd0;
    errors = 0;
    cycles = 0;
    quiet_run = 1'b0;
    // tables: reciprocal rounded in single, log rounded from double
    for (int k = 0; k < ROM_N; k++) begin
      recip_rom[k] = f_div(fln_pkg::F32_ONE, round_even(1'b0, 128'(ROM_N + k), -IDX_BITS));
      t = 1.0 + real'(k) / real'(ROM_N);
      ln_rom[k] = f_from_real($ln(t));
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed corners: signs, zeros, specials, subnormals, near-one edges
    foreach (corner_operands[i]) send_operand(corner_operands[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_run = (n >= 500 && n < 750);
      // drain the pipe completely once mid run
      if (n == 900) begin
        start <= 1'b0;
        @(posedge clk);
        while (board.pending_logs.size() != 0) @(posedge clk);
      end
      send_operand(pick_operand());
    end
    go_idle();

    waited = 0;
    while (board.pending_logs.size() != 0 && waited < 20 * PIPE_DEPTH) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (board.pending_logs.size() != 0) begin
      errors++;
      $display("%0d results never arrived", board.pending_logs.size());
    end

    $display("covered %0d operand transfers with %0d results checked", board.taken,
             board.checked);
    $display("operands spanned specials, subnormals, the near-one series and the table path");
    if (errors == 0) begin
      $display("float32_natural_log regression: pass");
    end else begin
      $display("float32_natural_log regression: fail");
    end
    $finish;
  end

endmodule
